>>> rtl/core/tpl_pkg.sv
// Shared types, constants and tables for the thermopile polynomial linearizer.
`default_nettype none

package tpl_pkg;

   localparam int CODE_W            = 16;
   localparam int TEMP_W            = 24;
   localparam int ACC_W             = 56;
   localparam int XMAG_W            = 30;
   localparam int COEF_W            = 32;
   localparam int QUOT_W            = 11;
   localparam int FRAC_W            = 19;
   localparam int STEPS             = 7;
   localparam int OUT_FRAC_BITS_DEF = 8;

   localparam logic signed [CODE_W:0] CODE_OFFSET = 17'sd7200;
   localparam logic [CODE_W-1:0]      RECIP_25    = 16'd41944;
   localparam int                     RECIP_SHIFT = 20;
   localparam logic [CODE_W-1:0]      DIVISOR     = 16'd25;

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   localparam acc_type ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam acc_type ACC_MIN = -ACC_MAX;
   localparam logic signed [63:0] SUM_MAX = 64'sd36028797018963967;
   localparam logic signed [63:0] SUM_MIN = -SUM_MAX;

   localparam coef_type DEG7_COEF [0:STEPS] = '{
      32'sd79, -32'sd2054, 32'sd13865, 32'sd28521,
      -32'sd357355, -32'sd4237925, 32'sd123159865, 32'sd418955605
   };

   localparam coef_type DEG3_COEF [0:STEPS] = '{
      32'sd0, 32'sd0, 32'sd0, 32'sd0,
      32'sd137573, -32'sd4684199, 32'sd119918507, 32'sd421193685
   };

   typedef struct packed {
      logic              x_neg;
      logic [XMAG_W-1:0] x_mag;
      logic              mode;
      logic              sat;
   } side_type;

   typedef struct packed {
      acc_type  acc;
      side_type side;
   } horner_type;

   // low bits of x magnitude: floor((r * 2^19 + 12) / 25)
   function automatic logic [FRAC_W-1:0] frac25(input logic [4:0] r);
      logic [FRAC_W-1:0] f;
      case (r)
         5'd0:    f = 19'd0;
         5'd1:    f = 19'd20972;
         5'd2:    f = 19'd41943;
         5'd3:    f = 19'd62915;
         5'd4:    f = 19'd83886;
         5'd5:    f = 19'd104858;
         5'd6:    f = 19'd125829;
         5'd7:    f = 19'd146801;
         5'd8:    f = 19'd167772;
         5'd9:    f = 19'd188744;
         5'd10:   f = 19'd209715;
         5'd11:   f = 19'd230687;
         5'd12:   f = 19'd251658;
         5'd13:   f = 19'd272630;
         5'd14:   f = 19'd293601;
         5'd15:   f = 19'd314573;
         5'd16:   f = 19'd335544;
         5'd17:   f = 19'd356516;
         5'd18:   f = 19'd377487;
         5'd19:   f = 19'd398459;
         5'd20:   f = 19'd419430;
         5'd21:   f = 19'd440402;
         5'd22:   f = 19'd461373;
         5'd23:   f = 19'd482345;
         5'd24:   f = 19'd503316;
         default: f = 19'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/tpl_norm.sv
// Front end: converts the converter code to a Q6.24 sign/magnitude x and seeds the accumulator.
`default_nettype none

module tpl_norm (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  wire  [tpl_pkg::CODE_W-1:0]     adc_code,
   input  wire                            accuracy_mode,
   output logic                           out_valid,
   input  wire                            out_ready,
   output tpl_pkg::horner_type            out_data
);
   import tpl_pkg::*;

   logic [3:0] v_ff;
   logic [3:0] en;

   logic signed [CODE_W:0] d_in;
   logic                   neg_in;
   logic [CODE_W-1:0]      ud_in;
   logic [CODE_W-1:0]      s1_ud_ff;
   logic                   s1_neg_ff;
   logic                   s1_mode_ff;

   logic [31:0]            prod_in;
   logic [30:0]            s2_prod_ff;
   logic [CODE_W-1:0]      s2_ud_ff;
   logic                   s2_neg_ff;
   logic                   s2_mode_ff;

   logic [QUOT_W-1:0]      q_in;
   logic [CODE_W-1:0]      q25_in;
   logic [CODE_W-1:0]      rem_in;
   logic [QUOT_W-1:0]      s3_q_ff;
   logic [4:0]             s3_r_ff;
   logic                   s3_neg_ff;
   logic                   s3_mode_ff;

   horner_type             out_in;
   horner_type             s4_ff;

   assign en[3]    = ~v_ff[3] | out_ready;
   assign en[2]    = ~v_ff[2] | en[3];
   assign en[1]    = ~v_ff[1] | en[2];
   assign en[0]    = ~v_ff[0] | en[1];
   assign in_ready = en[0];

   assign d_in   = $signed({adc_code[CODE_W-1], adc_code}) - CODE_OFFSET;
   assign neg_in = d_in[CODE_W];
   assign ud_in  = neg_in ? CODE_W'(-d_in) : CODE_W'(d_in);

   assign prod_in = s1_ud_ff * RECIP_25;

   assign q_in   = s2_prod_ff[30:RECIP_SHIFT];
   assign q25_in = CODE_W'(q_in) * DIVISOR;
   assign rem_in = s2_ud_ff - q25_in;

   always_comb begin
      out_in.acc        = s3_mode_ff ? ACC_W'(DEG7_COEF[0]) : ACC_W'(DEG3_COEF[0]);
      out_in.side.x_neg = s3_neg_ff;
      out_in.side.x_mag = {s3_q_ff, frac25(s3_r_ff)};
      out_in.side.mode  = s3_mode_ff;
      out_in.side.sat   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ud_ff   <= ud_in;
         s1_neg_ff  <= neg_in;
         s1_mode_ff <= accuracy_mode;
      end
      if (en[1]) begin
         s2_prod_ff <= prod_in[30:0];
         s2_ud_ff   <= s1_ud_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_mode_ff <= s1_mode_ff;
      end
      if (en[2]) begin
         s3_q_ff    <= q_in;
         s3_r_ff    <= rem_in[4:0];
         s3_neg_ff  <= s2_neg_ff;
         s3_mode_ff <= s2_mode_ff;
      end
      if (en[3]) begin
         s4_ff <= out_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = s4_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> (s3_r_ff < 5'd25))
      else $error("reciprocal quotient left remainder out of range");

endmodule

`default_nettype wire

>>> rtl/core/tpl_horner_step.sv
// One Horner step: acc = clamp(round(acc * x / 2^24) + coef), four register stages.
`default_nettype none

module tpl_horner_step (
   input  wire                            clock,
   input  wire                            reset,
   input  tpl_pkg::coef_type              coef_deg7,
   input  tpl_pkg::coef_type              coef_deg3,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  tpl_pkg::horner_type            in_data,
   output logic                           out_valid,
   input  wire                            out_ready,
   output tpl_pkg::horner_type            out_data
);
   import tpl_pkg::*;

   logic [3:0] v_ff;
   logic [3:0] en;

   logic [ACC_W-2:0]   ua_in;
   logic               neg_in;
   logic [ACC_W-2:0]   s1_ua_ff;
   logic               s1_neg_ff;
   side_type           s1_side_ff;

   logic [52:0]        phi_in;
   logic [61:0]        plo_in;
   logic [52:0]        s2_phi_ff;
   logic [61:0]        s2_plo_ff;
   logic               s2_neg_ff;
   side_type           s2_side_ff;

   logic [62:0]        lo_rnd_in;
   logic [61:0]        mag_in;
   logic [61:0]        s3_mag_ff;
   logic               s3_neg_ff;
   side_type           s3_side_ff;

   logic signed [63:0] smag_in;
   logic signed [63:0] sum_in;
   coef_type           coef_in;
   logic               hi_in;
   logic               lo_in;
   horner_type         out_in;
   horner_type         s4_ff;

   assign en[3]    = ~v_ff[3] | out_ready;
   assign en[2]    = ~v_ff[2] | en[3];
   assign en[1]    = ~v_ff[1] | en[2];
   assign en[0]    = ~v_ff[0] | en[1];
   assign in_ready = en[0];

   assign ua_in  = in_data.acc[ACC_W-1] ? (ACC_W-1)'(-in_data.acc) : (ACC_W-1)'(in_data.acc);
   assign neg_in = in_data.acc[ACC_W-1] ^ in_data.side.x_neg;

   assign phi_in = 53'(s1_ua_ff[ACC_W-2:32]) * 53'(s1_side_ff.x_mag);
   assign plo_in = 62'(s1_ua_ff[31:0]) * 62'(s1_side_ff.x_mag);

   assign lo_rnd_in = {1'b0, s2_plo_ff} + 63'(24'h800000);
   assign mag_in    = 62'({s2_phi_ff, 8'd0}) + 62'(lo_rnd_in[62:24]);

   always_comb begin
      smag_in = s3_neg_ff ? -$signed({2'b00, s3_mag_ff}) : $signed({2'b00, s3_mag_ff});
      coef_in = s3_side_ff.mode ? coef_deg7 : coef_deg3;
      sum_in  = smag_in + 64'(coef_in);
      hi_in   = sum_in > SUM_MAX;
      lo_in   = sum_in < SUM_MIN;
      out_in.side     = s3_side_ff;
      out_in.side.sat = s3_side_ff.sat | hi_in | lo_in;
      if (hi_in) begin
         out_in.acc = ACC_MAX;
      end else if (lo_in) begin
         out_in.acc = ACC_MIN;
      end else begin
         out_in.acc = sum_in[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ua_ff   <= ua_in;
         s1_neg_ff  <= neg_in;
         s1_side_ff <= in_data.side;
      end
      if (en[1]) begin
         s2_phi_ff  <= phi_in;
         s2_plo_ff  <= plo_in;
         s2_neg_ff  <= s1_neg_ff;
         s2_side_ff <= s1_side_ff;
      end
      if (en[2]) begin
         s3_mag_ff  <= mag_in;
         s3_neg_ff  <= s2_neg_ff;
         s3_side_ff <= s2_side_ff;
      end
      if (en[3]) begin
         s4_ff <= out_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = s4_ff;

   a_acc_in_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] |-> ((s4_ff.acc <= ACC_MAX) && (s4_ff.acc >= ACC_MIN)))
      else $error("accumulator left its clamp range");

endmodule

`default_nettype wire

>>> rtl/core/tpl_outscale.sv
// Back end: rounds the accumulator to the output scale, clips to 24 bits and holds the result beat.
`default_nettype none

module tpl_outscale #(
   parameter int OUT_FRAC_BITS = tpl_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  tpl_pkg::horner_type            in_data,
   output logic                           out_valid,
   input  wire                            out_ready,
   output logic [tpl_pkg::TEMP_W-1:0]     temperature_q8,
   output logic                           saturated
);
   import tpl_pkg::*;

   localparam int SH   = 24 - OUT_FRAC_BITS;
   localparam int UM_W = ACC_W - SH;
   localparam logic [UM_W-1:0] POS_LIMIT = UM_W'((1 << (TEMP_W - 1)) - 1);
   localparam logic [UM_W-1:0] NEG_LIMIT = UM_W'(1 << (TEMP_W - 1));
   localparam logic [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

   logic [2:0] v_ff;
   logic [2:0] en;

   logic [ACC_W-2:0]  ua_in;
   logic [ACC_W-2:0]  s1_ua_ff;
   logic              s1_neg_ff;
   logic              s1_sat_ff;

   logic [ACC_W-1:0]  rnd_in;
   logic [UM_W-1:0]   s2_um_ff;
   logic              s2_neg_ff;
   logic              s2_sat_ff;

   logic              over_pos_in;
   logic              over_neg_in;
   logic [UM_W-1:0]   um_neg_in;
   logic [TEMP_W-1:0] temp_in;
   logic [TEMP_W-1:0] temp_ff;
   logic              sat_ff;

   assign en[2]    = ~v_ff[2] | out_ready;
   assign en[1]    = ~v_ff[1] | en[2];
   assign en[0]    = ~v_ff[0] | en[1];
   assign in_ready = en[0];

   assign ua_in  = in_data.acc[ACC_W-1] ? (ACC_W-1)'(-in_data.acc) : (ACC_W-1)'(in_data.acc);
   assign rnd_in = {1'b0, s1_ua_ff} + (ACC_W'(1) << (SH - 1));

   always_comb begin
      over_pos_in = ~s2_neg_ff & (s2_um_ff > POS_LIMIT);
      over_neg_in = s2_neg_ff & (s2_um_ff > NEG_LIMIT);
      um_neg_in   = -s2_um_ff;
      if (over_pos_in) begin
         temp_in = TEMP_MAX;
      end else if (over_neg_in) begin
         temp_in = TEMP_MIN;
      end else if (s2_neg_ff) begin
         temp_in = um_neg_in[TEMP_W-1:0];
      end else begin
         temp_in = s2_um_ff[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ua_ff  <= ua_in;
         s1_neg_ff <= in_data.acc[ACC_W-1];
         s1_sat_ff <= in_data.side.sat;
      end
      if (en[1]) begin
         s2_um_ff  <= rnd_in[ACC_W-1:SH];
         s2_neg_ff <= s1_neg_ff;
         s2_sat_ff <= s1_sat_ff;
      end
      if (en[2]) begin
         temp_ff <= temp_in;
         sat_ff  <= s2_sat_ff | over_pos_in | over_neg_in;
      end
   end

   assign out_valid      = v_ff[2];
   assign temperature_q8 = temp_ff;
   assign saturated      = sat_ff;

endmodule

`default_nettype wire

>>> rtl/core/thermopile_poly_linearizer_core.sv
// Top level: thermopile code to linearized temperature, fully pipelined Horner evaluation.
`default_nettype none

// Takes one beat per cycle while no stall on the result side backs up, and returns one
// beat per input beat, in order. Each beat is a signed 16-bit converter code plus a
// mode bit (1: seventh-degree fit, 0: cubic fit); the result is the temperature in
// units of 2^-OUT_FRAC_BITS degree C, clipped to 24 bits, with a flag set when clipping
// or an accumulator clamp occurred. The pipeline runs through the normalizer (code
// offset, reciprocal multiply for the divide by 25, remainder fix-up), each of the 7
// Horner steps (magnitude, two split partial products, rounding add, coefficient add
// and clamp), and output rounding and clipping. Both fits run the same 7 steps, the
// cubic one with leading zero coefficients. Every stage carries its own valid bit and
// holds while its successor is full, so bubbles collapse and a stall on the result
// side lets up to 35 beats queue inside before req_tready drops.
module thermopile_poly_linearizer_core #(
   parameter int OUT_FRAC_BITS = tpl_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [15:0]                    req_tdata,  // [15:0] adc_code
   input  wire  [0:0]                     req_tuser,  // [0] accuracy_mode
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [23:0]                    rsp_tdata,  // [23:0] temperature_q8
   output logic [0:0]                     rsp_tuser   // [0] saturated
);
   import tpl_pkg::*;

   horner_type       stage_data  [0:STEPS];
   logic [STEPS:0]   stage_valid;
   logic [STEPS:0]   stage_ready;

   tpl_norm u_norm (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .adc_code      (req_tdata),
      .accuracy_mode (req_tuser[0]),
      .out_valid     (stage_valid[0]),
      .out_ready     (stage_ready[0]),
      .out_data      (stage_data[0])
   );

   for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
      tpl_horner_step u_step (
         .clock     (clock),
         .reset     (reset),
         .coef_deg7 (DEG7_COEF[gi+1]),
         .coef_deg3 (DEG3_COEF[gi+1]),
         .in_valid  (stage_valid[gi]),
         .in_ready  (stage_ready[gi]),
         .in_data   (stage_data[gi]),
         .out_valid (stage_valid[gi+1]),
         .out_ready (stage_ready[gi+1]),
         .out_data  (stage_data[gi+1])
      );
   end

   tpl_outscale #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_outscale (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_valid[STEPS]),
      .in_ready       (stage_ready[STEPS]),
      .in_data        (stage_data[STEPS]),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .temperature_q8 (rsp_tdata),
      .saturated      (rsp_tuser[0])
   );

   a_empty_takes_beat: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while result register empty");

endmodule

`default_nettype wire

>>> dv/thermopile_poly_linearizer_core_test.sv
// Self-checking stream testbench for the thermopile polynomial linearizer core.
`default_nettype none

module thermopile_poly_linearizer_core_test;

   localparam int      TEMP_FRAC   = 8;
   localparam int      TEMP_SHIFT  = 24 - TEMP_FRAC;
   localparam int      TAIL_CYCLES = 40;
   localparam longint  ACC_BOUND   = 64'sd36028797018963967;
   localparam longint  TEMP_MAX    = 64'sd8388607;
   localparam longint  TEMP_MIN    = -64'sd8388608;

   localparam longint FIT7 [0:7] = '{
      79, -2054, 13865, 28521, -357355, -4237925, 123159865, 418955605
   };
   localparam longint FIT3 [0:3] = '{137573, -4684199, 119918507, 421193685};

   typedef struct packed {
      logic [23:0] temp_q8;
      logic        saturated;
   } temp_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;  // [15:0] adc_code
   logic [0:0]  req_tuser;  // [0] accuracy_mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;  // [23:0] temperature_q8
   logic [0:0]  rsp_tuser;  // [0] saturated

   temp_beat_type pending_temps [$];
   int            errors;
   int            samples_sent;
   int            temps_checked;
   int            clipped_seen;
   int            fit7_sent;
   bit            sender_idle;
   bit            sink_idle;
   bit            sink_heavy;

   thermopile_poly_linearizer_core #(
      .OUT_FRAC_BITS(TEMP_FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint mul_round_q24(longint a, longint x);
      logic [127:0]    prod;
      longint unsigned ua;
      longint unsigned ux;
      longint          mag;
      bit              neg;
      neg  = (a < 0) != (x < 0);
      ua   = (a < 0) ? -a : a;
      ux   = (x < 0) ? -x : x;
      prod = 128'(ua) * 128'(ux);
      prod = (prod + (128'd1 << 23)) >> 24;
      mag  = longint'(prod[63:0]);
      return neg ? -mag : mag;
   endfunction

   function automatic temp_beat_type predict_temperature(logic signed [15:0] code, logic fit7);
      longint          delta;
      longint unsigned dmag;
      longint unsigned xmag;
      longint          x;
      longint          acc;
      longint          coef;
      longint unsigned amag;
      longint unsigned rmag;
      longint          t;
      int              terms;
      bit              sat;
      temp_beat_type   r;
      delta = longint'(code) - 7200;
      dmag  = (delta < 0) ? -delta : delta;
      xmag  = ((dmag << 24) + 400) / 800;
      x     = (delta < 0) ? -longint'(xmag) : longint'(xmag);
      sat   = 1'b0;
      terms = fit7 ? 8 : 4;
      acc   = fit7 ? FIT7[0] : FIT3[0];
      for (int i = 1; i < terms; i++) begin
         if (fit7) coef = FIT7[i];
         else coef = FIT3[i];
         acc = mul_round_q24(acc, x) + coef;
         if (acc > ACC_BOUND) begin
            acc = ACC_BOUND;
            sat = 1'b1;
         end else if (acc < -ACC_BOUND) begin
            acc = -ACC_BOUND;
            sat = 1'b1;
         end
      end
      amag = (acc < 0) ? -acc : acc;
      rmag = (amag + (64'd1 << (TEMP_SHIFT - 1))) >> TEMP_SHIFT;
      t    = (acc < 0) ? -longint'(rmag) : longint'(rmag);
      if (t > TEMP_MAX) begin
         t   = TEMP_MAX;
         sat = 1'b1;
      end
      if (t < TEMP_MIN) begin
         t   = TEMP_MIN;
         sat = 1'b1;
      end
      r.temp_q8   = t[23:0];
      r.saturated = sat;
      return r;
   endfunction

   function automatic logic [15:0] pick_code();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         5: begin
            return 16'(7200 + $signed($urandom_range(0, 400)) - 200);
         end
         6: begin
            return 16'h8000 + 16'($urandom_range(0, 255));
         end
         7: begin
            return 16'h7fff - 16'($urandom_range(0, 255));
         end
         8: begin
            return 16'($signed($urandom_range(0, 2000)) - 1000);
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   task automatic send_sample(logic [15:0] code, logic fit7);
      int gap;
      req_tdata  <= code;
      req_tuser  <= fit7;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_temps.push_back(predict_temperature(code, fit7));
      samples_sent++;
      if (fit7) fit7_sent++;
      gap = sender_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic end_stream();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_temps.size() != 0) @(posedge clock);
   endtask

   task automatic test_edge_codes();
      logic [15:0] codes [0:11];
      codes = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001, 16'd7199,
                16'd7200, 16'd7201, 16'h5555, 16'haaaa, 16'd16000, 16'he0c0};
      sender_idle = 1'b0;
      sink_idle   = 1'b0;
      foreach (codes[i]) begin
         send_sample(codes[i], 1'b0);
         send_sample(codes[i], 1'b1);
      end
      end_stream();
   endtask

   task automatic test_full_rate();
      sender_idle = 1'b0;
      sink_idle   = 1'b0;
      repeat (300) send_sample(pick_code(), 1'($urandom));
      end_stream();
   endtask

   task automatic test_random_idle();
      sender_idle = 1'b1;
      sink_idle   = 1'b1;
      sink_heavy  = 1'b0;
      repeat (700) send_sample(pick_code(), 1'($urandom));
      end_stream();
   endtask

   task automatic test_drain_pause();
      sender_idle = 1'b1;
      sink_idle   = 1'b1;
      repeat (4) begin
         repeat (25) send_sample(pick_code(), 1'($urandom));
         end_stream();
         wait_drained();
      end
   endtask

   task automatic test_result_backpressure();
      sender_idle = 1'b0;
      sink_idle   = 1'b1;
      sink_heavy  = 1'b1;
      repeat (320) send_sample(pick_code(), 1'($urandom));
      end_stream();
      sink_heavy = 1'b0;
   endtask

   initial begin : result_sink
      int left;
      int stall;
      bit level;
      left  = 0;
      level = 1'b1;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!sink_idle) begin
            level = 1'b1;
            left  = 0;
         end else begin
            if (left == 0) begin
               if (level) begin
                  stall = sink_heavy ? $urandom_range(5, 60) : pick_gap();
                  if (stall > 0) begin
                     level = 1'b0;
                     left  = stall;
                  end else begin
                     left = pick_gap() + 1;
                  end
               end else begin
                  level = 1'b1;
                  left  = sink_heavy ? $urandom_range(1, 4) : pick_gap() + 1;
               end
            end
            left--;
         end
         rsp_tready <= level;
      end
   end

   always @(posedge clock) begin : result_check
      temp_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_temps.size() == 0) begin
            $error("unexpected result beat: temperature_q8 %0d saturated %0d",
                   $signed(rsp_tdata), rsp_tuser[0]);
            errors++;
         end else begin
            want = pending_temps.pop_front();
            temps_checked++;
            if (rsp_tuser[0]) clipped_seen++;
            if (rsp_tdata !== want.temp_q8) begin
               $error("temperature_q8 mismatch: expected %0d, actual %0d",
                      $signed(want.temp_q8), $signed(rsp_tdata));
               errors++;
            end
            if (rsp_tuser[0] !== want.saturated) begin
               $error("saturated mismatch: expected %0d, actual %0d",
                      want.saturated, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      errors        = 0;
      samples_sent  = 0;
      temps_checked = 0;
      clipped_seen  = 0;
      fit7_sent     = 0;
      sender_idle   = 1'b0;
      sink_idle     = 1'b0;
      sink_heavy    = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_codes();
      test_full_rate();
      test_random_idle();
      test_drain_pause();
      test_result_backpressure();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_temps.size() != 0) begin
         $error("%0d expected results never arrived", pending_temps.size());
         errors++;
      end
      $display("tb: %0d samples (%0d on the seventh-degree fit), %0d results checked",
               samples_sent, fit7_sent, temps_checked);
      $display("tb: %0d clipped results, %0d mismatches", clipped_seen, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
rtl/core/tpl_pkg.sv
rtl/core/tpl_norm.sv
rtl/core/tpl_horner_step.sv
rtl/core/tpl_outscale.sv
rtl/core/thermopile_poly_linearizer_core.sv
dv/thermopile_poly_linearizer_core_test.sv
